// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ===== src/vsh_pkg.sv =====
// Package with sizes, codes and shared types of the validator set history.
`default_nettype none
package vsh_pkg;
   localparam int MAX_ADDRESSES   = 256;
   localparam int MAX_ENTRIES     = 64;
   localparam int MAX_LIST_LENGTH = 64;
   localparam int SLOT_LIST_DEPTH = 1024;
   localparam int AW = $clog2(MAX_ADDRESSES);
   localparam int EW = $clog2(MAX_ENTRIES);
   localparam int SW = $clog2(SLOT_LIST_DEPTH);
   localparam int LW = $clog2(MAX_LIST_LENGTH + 1);

   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_ADDR  = 2'd0;
   localparam logic [1:0] ST_OK    = 2'd1;
   localparam logic [1:0] ST_NONE  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [31:0] high;
      logic [63:0] middle;
      logic [63:0] low;
   } addr_type;

   typedef struct packed {
      logic [1:0] status;
      logic       last;
      addr_type   addr;
      logic [7:0] slot;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/vsh_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read data.
`default_nettype none
module vsh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/validator_set_history.sv =====
// Top level of the validator set history.
// The block keeps lists of 160-bit addresses keyed by block number.
// Input beats arrive on req_ (tuser = func, tdata = block number and the
// address parts); result beats leave on rsp_ (tuser = status, tlast = the
// last result of an input beat, tdata = address parts and slot index).
// One item is worked on at a time; req_tready is high only while idle.
// An append searches the address table one slot per cycle through the
// table RAM port. A query scans the entry RAM one entry per cycle and
// then reads the slot list and table for each address, two RAM reads in
// a row, up to 64 addresses.
// A result beat is held in an output register until rsp_tready takes it;
// the sequencer waits there, so a stalled receiver stalls the block but no
// beat is lost. Reset clears the fill counts, the current list length, the
// output valid and the sequencer only; the RAMs keep their contents, and
// their data is used only below the fill counts.
`default_nettype none
module validator_set_history (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0: block_number(64), address_high(32), address_middle(64),
   // address_low(64)
   input  wire logic [223:0] req_tdata,
   // tuser: func(2)
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata from bit 0: out_address_high(32), out_address_middle(64),
   // out_address_low(64), slot_index(8)
   output logic [167:0]      rsp_tdata,
   // tuser: status(2)
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import vsh_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SRCH  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_SLOT  = 7'b0001000,
      S_ADDR  = 7'b0010000,
      S_OUT   = 7'b0100000,
      S_WAIT  = 7'b1000000
   } state_type;

   state_type state_ff;
   logic [1:0]  func_ff;
   logic [63:0] blk_ff;
   logic [63:0] cur_blk_ff;     // block number of the current (last) entry
   addr_type    key_ff;
   logic [AW:0] tfill_ff;
   logic [EW:0] efill_ff;
   logic [SW:0] sfill_ff;
   logic [LW-1:0] cur_len_ff;   // length of the current (last) entry
   logic [AW:0] idx_ff;          // table search position
   logic [EW:0] eidx_ff;
   logic        have_ff, rd_pend_ff;
   logic [EW-1:0] chosen_ff;
   logic [LW-1:0] qlen_ff, qpos_ff;
   logic [SW-1:0] qstart_ff;
   logic        more_ff;        // query continues after this beat
   rsp_type     rsp_ff;
   logic        rv_ff;

   // table RAM
   logic          t_we;
   logic [AW-1:0] t_waddr, t_raddr;
   addr_type      t_rdata;
   vsh_ram #(.WIDTH(160), .DEPTH(MAX_ADDRESSES)) u_table (
      .clock, .wr_en(t_we), .wr_addr(t_waddr), .wr_data(key_ff),
      .rd_addr(t_raddr), .rd_data(t_rdata));
   // entry RAM: block, length, start
   localparam int EDW = 64 + LW + SW;
   logic          e_we;
   logic [EW-1:0] e_waddr, e_raddr;
   logic [EDW-1:0] e_wdata, e_rdata;
   vsh_ram #(.WIDTH(EDW), .DEPTH(MAX_ENTRIES)) u_entry (
      .clock, .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
      .rd_addr(e_raddr), .rd_data(e_rdata));
   // slot list RAM
   logic          s_we;
   logic [SW-1:0] s_raddr;
   logic [AW-1:0] s_wdata, s_rdata;
   vsh_ram #(.WIDTH(AW), .DEPTH(SLOT_LIST_DEPTH)) u_slots (
      .clock, .wr_en(s_we), .wr_addr(sfill_ff[SW-1:0]), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata));

   logic [63:0]   e_blk;
   logic [LW-1:0] e_len;
   logic [SW-1:0] e_st;
   assign {e_blk, e_len, e_st} = e_rdata;

   state_type state_in;
   rsp_type rsp_in;
   logic rv_in, take_in;
   logic [AW:0] idx_in;
   logic [EW:0] eidx_in;
   logic have_in, rd_pend_in, more_in;
   logic [EW-1:0] chosen_in;
   logic [LW-1:0] qlen_in, qpos_in, cur_len_in;
   logic [SW-1:0] qstart_in;
   logic [AW:0] tfill_in;
   logic [EW:0] efill_in;
   logic [SW:0] sfill_in;
   logic accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tuser = rsp_ff.status;
   assign rsp_tlast = rsp_ff.last;
   assign rsp_tdata = {rsp_ff.slot, rsp_ff.addr.low, rsp_ff.addr.middle,
                       rsp_ff.addr.high};

   function automatic rsp_type mk(input logic [1:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      rsp_in = rsp_ff;
      rv_in = rv_ff && !rsp_tready;
      take_in = 1'b0;
      idx_in = idx_ff; eidx_in = eidx_ff; have_in = have_ff;
      rd_pend_in = 1'b0; more_in = more_ff; chosen_in = chosen_ff;
      qlen_in = qlen_ff; qpos_in = qpos_ff; qstart_in = qstart_ff;
      cur_len_in = cur_len_ff;
      tfill_in = tfill_ff; efill_in = efill_ff; sfill_in = sfill_ff;
      t_we = 1'b0; t_waddr = tfill_ff[AW-1:0]; t_raddr = idx_ff[AW-1:0];
      e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = eidx_ff[EW-1:0];
      s_we = 1'b0; s_wdata = '0; s_raddr = qstart_ff + SW'(qpos_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = '0; eidx_in = '0; have_in = 1'b0; chosen_in = '0;
               case (req_tuser)
                  FUNC_START: begin
                     if (efill_ff >= (EW+1)'(MAX_ENTRIES)) begin
                        rsp_in = mk(ST_FULL);
                     end else begin
                        rsp_in = mk(ST_OK);
                        cur_len_in = '0;
                     end
                     state_in = S_OUT; more_in = 1'b0;
                  end
                  FUNC_APPEND: begin
                     more_in = 1'b0;
                     if (efill_ff == '0) begin
                        rsp_in = mk(ST_NONE); state_in = S_OUT;
                     end else if (cur_len_ff >= LW'(MAX_LIST_LENGTH) ||
                                  sfill_ff >= (SW+1)'(SLOT_LIST_DEPTH)) begin
                        rsp_in = mk(ST_FULL); state_in = S_OUT;
                     end else begin
                        state_in = S_SRCH;
                     end
                  end
                  FUNC_QUERY: begin
                     state_in = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SRCH: begin
            // one table read per cycle; data of slot idx-1 arrives now
            if (rd_pend_ff && t_rdata == key_ff) begin
               rsp_in = mk(ST_OK); rsp_in.addr = key_ff;
               rsp_in.slot = 8'(idx_ff - 1'b1);
               s_we = 1'b1; s_wdata = AW'(idx_ff - 1'b1);
               state_in = S_OUT;
            end else if (idx_ff >= tfill_ff) begin
               if (tfill_ff >= (AW+1)'(MAX_ADDRESSES)) begin
                  rsp_in = mk(ST_FULL);
               end else begin
                  t_we = 1'b1; tfill_in = tfill_ff + 1'b1;
                  rsp_in = mk(ST_OK); rsp_in.addr = key_ff;
                  rsp_in.slot = 8'(tfill_ff);
                  s_we = 1'b1; s_wdata = tfill_ff[AW-1:0];
               end
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1; rd_pend_in = 1'b1;
            end
            if (s_we) begin
               sfill_in = sfill_ff + 1'b1;
               cur_len_in = cur_len_ff + 1'b1;
               e_we = 1'b1; e_waddr = EW'(efill_ff - 1'b1);
               e_wdata = {cur_blk_ff, cur_len_ff + 1'b1, qstart_ff};
            end
         end
         S_SCAN: begin
            if (rd_pend_ff && e_blk > blk_ff) begin
               eidx_in = eidx_ff; // stop
               state_in = S_SLOT;
            end else begin
               if (rd_pend_ff) begin
                  have_in = 1'b1; chosen_in = EW'(eidx_ff - 1'b1);
                  qlen_in = e_len; qstart_in = e_st;
               end
               if (eidx_ff >= efill_ff) begin
                  state_in = S_SLOT;
               end else begin
                  eidx_in = eidx_ff + 1'b1; rd_pend_in = 1'b1;
               end
            end
            if (state_in == S_SLOT) begin
               qpos_in = '0;
               if (!have_in || qlen_in == '0) begin
                  rsp_in = mk(ST_NONE); more_in = 1'b0; state_in = S_OUT;
               end
            end
         end
         S_SLOT: begin
            // slot list read issued this cycle at start+pos
            state_in = S_ADDR;
         end
         S_ADDR: begin
            t_raddr = s_rdata; // table read
            rsp_in = '0; rsp_in.slot = 8'(s_rdata);
            state_in = S_WAIT;
         end
         S_WAIT: begin
            rsp_in.addr = t_rdata; rsp_in.status = ST_ADDR;
            rsp_in.last = (qpos_ff + 1'b1 == qlen_ff);
            more_in = !rsp_in.last;
            qpos_in = qpos_ff + 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Present the beat, then hold here until the receiver takes it,
            // so the output register is never rebuilt while it is valid.
            if (!rv_ff) begin
               rv_in = 1'b1;
            end else if (rsp_tready) begin
               state_in = more_ff ? S_SLOT : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE && accept && req_tuser == FUNC_START &&
          efill_ff < (EW+1)'(MAX_ENTRIES)) begin
         e_we = 1'b1; e_waddr = efill_ff[EW-1:0];
         e_wdata = {req_tdata[63:0], LW'(0), sfill_ff[SW-1:0]};
         efill_in = efill_ff + 1'b1;
         qstart_in = sfill_ff[SW-1:0];
         take_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; rd_pend_ff <= 1'b0;
         tfill_ff <= '0; efill_ff <= '0; sfill_ff <= '0; cur_len_ff <= '0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; rd_pend_ff <= rd_pend_in;
         tfill_ff <= tfill_in; efill_ff <= efill_in; sfill_ff <= sfill_in;
         cur_len_ff <= cur_len_in;
      end
   end

   // Payload registers. qstart holds the current entry start between items,
   // except during a query, which reloads it; the next append restores it.
   // The current entry's block number is kept so that an append can rewrite
   // the entry word without touching it.
   logic [SW-1:0] cur_start_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_tuser; blk_ff <= req_tdata[63:0];
         key_ff <= {req_tdata[95:64], req_tdata[159:96], req_tdata[223:160]};
      end
      if (take_in) begin
         cur_start_ff <= sfill_ff[SW-1:0];
         cur_blk_ff <= req_tdata[63:0];
      end
      idx_ff <= idx_in; eidx_ff <= eidx_in; have_ff <= have_in;
      more_ff <= more_in; chosen_ff <= chosen_in; qlen_ff <= qlen_in;
      qpos_ff <= qpos_in; rsp_ff <= rsp_in;
      if (accept && req_tuser == FUNC_APPEND) begin
         qstart_ff <= cur_start_ff;
      end else begin
         qstart_ff <= qstart_in;
      end
   end

   `ASSERT_IMPLIES(a_ready_idle, clock, reset, req_tready, state_ff == S_IDLE)
   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1,
      efill_ff <= (EW+1)'(MAX_ENTRIES) && tfill_ff <= (AW+1)'(MAX_ADDRESSES))
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLIES(a_func_used, clock, reset, state_ff == S_SRCH,
      func_ff == FUNC_APPEND)
endmodule
`default_nettype wire

// ===== bench/vsh_checker.sv =====
// Checker that predicts and compares the result beats of the validator set history.
`default_nettype none
module vsh_checker
   import vsh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [223:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [167:0] rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   input  wire logic         rsp_tlast,
   output int                fail_count,
   output int                pending_count,
   output int                delivered_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic        last;
      logic [31:0] high;
      logic [63:0] middle;
      logic [63:0] low;
      logic [7:0]  slot;
   } beat_type;

   // Shadow copy of the block's stores.
   logic [31:0] addr_high_tab [MAX_ADDRESSES];
   logic [63:0] addr_mid_tab  [MAX_ADDRESSES];
   logic [63:0] addr_low_tab  [MAX_ADDRESSES];
   int          addr_count;
   logic [63:0] hist_block [MAX_ENTRIES];
   int          hist_len   [MAX_ENTRIES];
   int          hist_first [MAX_ENTRIES];
   int          hist_count;
   int          slot_run [SLOT_LIST_DEPTH];
   int          slot_count;

   beat_type expected_beats[$];

   function automatic beat_type mk(logic [1:0] st, logic lst, logic [31:0] h,
                                   logic [63:0] m, logic [63:0] l, logic [7:0] s);
      beat_type b;
      b.status = st; b.last = lst; b.high = h; b.middle = m; b.low = l; b.slot = s;
      return b;
   endfunction

   task automatic predict_history(logic [1:0] fn, logic [63:0] blk, logic [31:0] h,
                                  logic [63:0] m, logic [63:0] l);
      int cur, slot, chosen, n;
      bit found, have;
      found = 0; have = 0; slot = 0; chosen = 0;
      case (fn)
         FUNC_START: begin
            if (hist_count >= MAX_ENTRIES) begin
               expected_beats.push_back(mk(ST_FULL, 1, 0, 0, 0, 0));
            end else begin
               hist_block[hist_count] = blk;
               hist_len[hist_count] = 0;
               hist_first[hist_count] = slot_count;
               hist_count++;
               expected_beats.push_back(mk(ST_OK, 1, 0, 0, 0, 0));
            end
         end
         FUNC_APPEND: begin
            if (hist_count == 0) begin
               expected_beats.push_back(mk(ST_NONE, 1, 0, 0, 0, 0));
               return;
            end
            cur = hist_count - 1;
            if (hist_len[cur] >= MAX_LIST_LENGTH || slot_count >= SLOT_LIST_DEPTH) begin
               expected_beats.push_back(mk(ST_FULL, 1, 0, 0, 0, 0));
               return;
            end
            for (int i = 0; i < addr_count; i++) begin
               if (!found && addr_high_tab[i] == h && addr_mid_tab[i] == m &&
                   addr_low_tab[i] == l) begin
                  slot = i; found = 1;
               end
            end
            if (!found) begin
               if (addr_count >= MAX_ADDRESSES) begin
                  expected_beats.push_back(mk(ST_FULL, 1, 0, 0, 0, 0));
                  return;
               end
               slot = addr_count;
               addr_high_tab[slot] = h; addr_mid_tab[slot] = m; addr_low_tab[slot] = l;
               addr_count++;
            end
            slot_run[slot_count] = slot;
            slot_count++;
            hist_len[cur]++;
            expected_beats.push_back(mk(ST_OK, 1, h, m, l, slot[7:0]));
         end
         FUNC_QUERY: begin
            for (int e = 0; e < hist_count; e++) begin
               if (hist_block[e] > blk) break;
               chosen = e; have = 1;
            end
            if (!have || hist_len[chosen] == 0) begin
               expected_beats.push_back(mk(ST_NONE, 1, 0, 0, 0, 0));
               return;
            end
            n = hist_len[chosen];
            for (int j = 0; j < n; j++) begin
               slot = slot_run[hist_first[chosen] + j];
               expected_beats.push_back(mk(ST_ADDR, j == n - 1, addr_high_tab[slot],
                                           addr_mid_tab[slot], addr_low_tab[slot],
                                           slot[7:0]));
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      beat_type got, want;
      if (reset) begin
         addr_count = 0; hist_count = 0; slot_count = 0;
         expected_beats.delete();
         fail_count = 0; delivered_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = mk(rsp_tuser, rsp_tlast, rsp_tdata[31:0], rsp_tdata[95:32],
                     rsp_tdata[159:96], rsp_tdata[167:160]);
            delivered_count++;
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat %p", got);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $error("is_last: expected %0d actual %0d", want.last, got.last);
                  fail_count++;
               end
               if (got.high !== want.high) begin
                  $error("out_address_high: expected %h actual %h", want.high, got.high);
                  fail_count++;
               end
               if (got.middle !== want.middle) begin
                  $error("out_address_middle: expected %h actual %h",
                         want.middle, got.middle);
                  fail_count++;
               end
               if (got.low !== want.low) begin
                  $error("out_address_low: expected %h actual %h", want.low, got.low);
                  fail_count++;
               end
               if (got.slot !== want.slot) begin
                  $error("slot_index: expected %0d actual %0d", want.slot, got.slot);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_history(req_tuser, req_tdata[63:0], req_tdata[95:64],
                            req_tdata[159:96], req_tdata[223:160]);
      end
      pending_count = expected_beats.size();
   end
endmodule
`default_nettype wire

// ===== bench/tb_validator_set_history.sv =====
// Testbench top for the validator set history: stimulus, idling and verdict.
`default_nettype none
module tb_validator_set_history;
   import vsh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [167:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   int           fail_count, pending_count, delivered_count;

   // Idle percentages of sender and receiver for the current phase.
   int           send_idle_pct = 36;
   int           recv_idle_pct = 50;
   int           sent_beats = 0;

   // A small pool of addresses so that appends often hit an existing slot.
   logic [159:0] addr_pool [16];

   always #5 clock = ~clock;

   validator_set_history u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   vsh_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending_count(pending_count),
      .delivered_count(delivered_count)
   );

   // The receiver stalls at random; its rate changes with the phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Sends one beat: optional random gaps, then hold tvalid until accepted.
   // tvalid stays high after the accept; the next gap or a drain drops it.
   task automatic send_beat(logic [1:0] fn, logic [63:0] blk, logic [159:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= fn;
      req_tdata  <= {addr[63:0], addr[127:64], addr[159:128], blk};
      do @(posedge clock); while (!req_tready);
      sent_beats++;
   endtask

   function automatic logic [159:0] rand_addr();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_block();
      return {$urandom, $urandom};
   endfunction

   // Waits until every expected result beat has been seen, plus a margin.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // One random beat. Mostly well-formed: starts with growing blocks, appends
   // from the pool or fresh, queries near stored blocks; a few unused funcs.
   task automatic random_beat(ref logic [63:0] last_block);
      int pick;
      logic [63:0] q;
      pick = $urandom_range(99);
      if (pick < 12) begin
         last_block = last_block + $urandom_range(1, 50);
         send_beat(FUNC_START, last_block, rand_addr());
      end else if (pick < 60) begin
         send_beat(FUNC_APPEND, rand_block(),
                   ($urandom_range(1) != 0) ? addr_pool[$urandom_range(15)] : rand_addr());
      end else if (pick < 95) begin
         q = ($urandom_range(3) == 0) ? rand_block()
                                      : last_block - $urandom_range(0, 150);
         send_beat(FUNC_QUERY, q, rand_addr());
      end else begin
         send_beat(FUNC_UNUSED, rand_block(), rand_addr());
      end
   endtask

   initial begin
      logic [63:0] last_block;
      for (int i = 0; i < 16; i++) addr_pool[i] = rand_addr();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: empty-store cases, extremes, every func, unused func.
      send_beat(FUNC_APPEND, 0, '1);                  // append with no entry open
      send_beat(FUNC_QUERY, '1, '0);                  // query with no entries
      send_beat(FUNC_START, 100, '0);
      send_beat(FUNC_QUERY, 99, '0);                  // first entry exceeds block
      send_beat(FUNC_QUERY, 100, '0);                 // chosen list empty
      send_beat(FUNC_APPEND, 0, '1);
      send_beat(FUNC_APPEND, 0, '0);
      send_beat(FUNC_APPEND, 0, '1);                  // duplicate address
      send_beat(FUNC_APPEND, 0, {32'hAAAAAAAA, {2{32'h55555555}}, {2{32'hAAAAAAAA}}});
      send_beat(FUNC_UNUSED, '1, '1);                 // unused func, ignored
      send_beat(FUNC_START, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      send_beat(FUNC_APPEND, 0, addr_pool[0]);
      send_beat(FUNC_QUERY, 500, '0);                 // picks the first entry
      send_beat(FUNC_QUERY, '1, '0);                  // last entry
      send_beat(FUNC_START, 0, '0);                   // lower block after higher
      send_beat(FUNC_QUERY, 0, '0);
      send_beat(FUNC_QUERY, '1, '0);
      // Full list: fill the current entry past its length limit.
      send_beat(FUNC_START, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      for (int i = 0; i < MAX_LIST_LENGTH + 1; i++)
         send_beat(FUNC_APPEND, 0, ($urandom_range(1) != 0) ? addr_pool[i % 16] : rand_addr());
      send_beat(FUNC_QUERY, '1, '0);                  // a full 64-address list
      // Hold off until the block has delivered everything.
      drain();

      last_block = 1000;
      send_beat(FUNC_START, last_block, '0);
      for (int i = 0; i < 25; i++) random_beat(last_block);
      drain();
      send_idle_pct = 50; recv_idle_pct = 36;
      for (int i = 0; i < 25; i++) random_beat(last_block);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      for (int i = 0; i < 25; i++) random_beat(last_block);
      // Exhaust the entry store to reach the full-entries case.
      for (int i = 0; i < MAX_ENTRIES + 2; i++) begin
         last_block = last_block + 1;
         send_beat(FUNC_START, last_block, '0);
      end
      send_beat(FUNC_APPEND, 0, addr_pool[3]);
      send_beat(FUNC_QUERY, '1, '0);
      drain();

      $display("Sent %0d request beats and checked %0d result beats over three idling phases,",
               sent_beats, delivered_count);
      $display("including empty, duplicate, full-list and full-entry cases.");
      if (fail_count == 0 && pending_count == 0)
         $display("[validator_set_history] OK");
      else
         $display("[validator_set_history] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[validator_set_history] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

// ===== validator_set_history.f =====
+incdir+src
src/vsh_pkg.sv
src/vsh_ram.sv
src/validator_set_history.sv
bench/vsh_checker.sv
bench/tb_validator_set_history.sv
